@@ rtl/dq_pkg.sv @@
// shared types and codes for the bounded deque
package dq_pkg;

   localparam int unsigned DATA_W = 32;

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_REMOVE     = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_FULL = 2'd1,
      ST_NONE = 2'd2
   } status_type;

   // what every cell of the row does with its stored value
   typedef enum logic [1:0] {
      CMD_HOLD       = 2'd0,
      CMD_SHIFT_UP   = 2'd1,
      CMD_LOAD_AT    = 2'd2,
      CMD_SHIFT_DOWN = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

@@ rtl/dq_cell.sv @@
// one storage cell of the deque row
module dq_cell #(
   parameter int unsigned IDX_W    = 5,
   parameter int unsigned CELL_IDX = 0
) (
   input  logic                                clock,
   input  dq_pkg::cell_cmd_type                cmd,
   input  logic [IDX_W-1:0]                    target,
   input  logic signed [dq_pkg::DATA_W-1:0]    left_data,
   input  logic signed [dq_pkg::DATA_W-1:0]    right_data,
   output logic signed [dq_pkg::DATA_W-1:0]    data,
   output logic signed [dq_pkg::DATA_W-1:0]    pick_data
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic signed [dq_pkg::DATA_W-1:0] data_ff;
   logic signed [dq_pkg::DATA_W-1:0] data_in;
   logic                             hit;
   logic                             at_or_above;

   assign hit         = (target == MY_IDX);
   assign at_or_above = (MY_IDX >= target);

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         dq_pkg::CMD_SHIFT_UP: begin
            data_in = (CELL_IDX == 0) ? cmd.value : left_data;
         end
         dq_pkg::CMD_LOAD_AT: begin
            if (hit) begin
               data_in = cmd.value;
            end
         end
         dq_pkg::CMD_SHIFT_DOWN: begin
            // close the gap left by the removed entry
            if (at_or_above) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign pick_data = (hit && cmd.op == dq_pkg::CMD_SHIFT_DOWN) ? data_ff : '0;

endmodule

@@ rtl/dq_row.sv @@
// row of chained cells holding the deque entries, front at cell 0
module dq_row #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned IDX_W = 5
) (
   input  logic                             clock,
   input  dq_pkg::cell_cmd_type             cmd,
   input  logic [IDX_W-1:0]                 target,
   output logic signed [dq_pkg::DATA_W-1:0] removed_value
);

   logic signed [dq_pkg::DATA_W-1:0] data_w [DEPTH];
   logic signed [dq_pkg::DATA_W-1:0] pick_w [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [dq_pkg::DATA_W-1:0] left_w;
      logic signed [dq_pkg::DATA_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = data_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_right
         assign right_w = data_w[i+1];
      end

      dq_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .target     (target),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (data_w[i]),
         .pick_data  (pick_w[i])
      );
   end

   // at most one cell offers its value, the rest give zero
   always_comb begin
      removed_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         removed_value = removed_value | pick_w[i];
      end
   end

endmodule

@@ rtl/bounded_deque_with_indexed_delete.sv @@
// bounded deque top level: request decode, length counter and response register
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  action, value, position
//   rsp_     out        rsp_valid / rsp_ready  status, removed_value, length
//
// every request is decoded and applied to the cell row in the cycle it is taken,
// all cells shifting at once, so one request per cycle is accepted while the response is drained.
// the response appears in the cycle after its request is taken and sits in an output register.
// a new request is taken while the response register is empty or being drained.
// reset clears the length and the response valid; cell contents are not cleared.
module bounded_deque_with_indexed_delete #(
   parameter int unsigned DEPTH = 16,
   localparam int unsigned POS_W = $clog2(DEPTH),
   localparam int unsigned LEN_W = $clog2(DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_action,
   input  logic signed [dq_pkg::DATA_W-1:0] req_value,
   input  logic [POS_W-1:0]                 req_position,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_removed_value,
   output logic [LEN_W-1:0]                 rsp_length
);

   localparam logic [LEN_W-1:0] FULL_COUNT = LEN_W'(DEPTH);

   logic [LEN_W-1:0]                 count_ff;
   logic [LEN_W-1:0]                 count_in;
   logic                             rsp_valid_ff;
   dq_pkg::status_type               rsp_status_ff;
   logic signed [dq_pkg::DATA_W-1:0] rsp_removed_ff;
   logic [LEN_W-1:0]                 rsp_length_ff;

   logic                             req_fire;
   logic                             is_full;
   logic                             is_empty;
   dq_pkg::status_type               status_in;
   dq_pkg::cell_cmd_type             cmd;
   logic [LEN_W-1:0]                 target;
   logic signed [dq_pkg::DATA_W-1:0] removed_value;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_full   = (count_ff == FULL_COUNT);
   assign is_empty  = (count_ff == '0);

   always_comb begin
      cmd.op    = dq_pkg::CMD_HOLD;
      cmd.value = req_value;
      target    = '0;
      status_in = dq_pkg::ST_DONE;
      count_in  = count_ff;
      case (dq_pkg::action_type'(req_action))
         dq_pkg::ACT_PUSH_FRONT: begin
            if (is_full) begin
               status_in = dq_pkg::ST_FULL;
            end else begin
               cmd.op   = dq_pkg::CMD_SHIFT_UP;
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::ACT_PUSH_BACK: begin
            if (is_full) begin
               status_in = dq_pkg::ST_FULL;
            end else begin
               cmd.op   = dq_pkg::CMD_LOAD_AT;
               target   = count_ff;
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::ACT_POP_FRONT: begin
            if (is_empty) begin
               status_in = dq_pkg::ST_NONE;
            end else begin
               cmd.op   = dq_pkg::CMD_SHIFT_DOWN;
               target   = '0;
               count_in = count_ff - 1'b1;
            end
         end
         dq_pkg::ACT_POP_BACK: begin
            if (is_empty) begin
               status_in = dq_pkg::ST_NONE;
            end else begin
               cmd.op   = dq_pkg::CMD_SHIFT_DOWN;
               target   = count_ff - 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         dq_pkg::ACT_REMOVE: begin
            if (LEN_W'(req_position) >= count_ff) begin
               status_in = dq_pkg::ST_NONE;
            end else begin
               cmd.op   = dq_pkg::CMD_SHIFT_DOWN;
               target   = LEN_W'(req_position);
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = dq_pkg::ST_NONE;
         end
      endcase
      // nothing moves unless a request is taken this cycle
      if (!req_fire) begin
         cmd.op   = dq_pkg::CMD_HOLD;
         count_in = count_ff;
      end
   end

   dq_row #(
      .DEPTH (DEPTH),
      .IDX_W (LEN_W)
   ) u_row (
      .clock         (clock),
      .cmd           (cmd),
      .target        (target),
      .removed_value (removed_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff  <= status_in;
         rsp_removed_ff <= removed_value;
         rsp_length_ff  <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_length        = rsp_length_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("deque length beyond capacity");

   a_rsp_length: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid && rsp_length == count_ff)
      else $error("response length differs from stored length");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_status != dq_pkg::ST_FULL || $past(count_ff) == FULL_COUNT)
      else $error("full reported while space was left");

   a_removed_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == dq_pkg::ST_DONE || rsp_removed_value == '0)
      else $error("removed value on refused request");
`endif

endmodule

@@ tb/sv/tb_bounded_deque_with_indexed_delete.sv @@
// self-checking testbench for the bounded deque with delete at a position
`timescale 1ns / 1ps

module tb_bounded_deque_with_indexed_delete;

   localparam int unsigned DEPTH = 16;
   localparam int unsigned POS_W = 4;
   localparam int unsigned LEN_W = 5;
   localparam int RANDOM_REQS = 1625;
   localparam int PHASE_LEN = 550;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 8;
   localparam int REPORT_MAX = 10;

   // action codes the block treats as no such element
   localparam logic [2:0] ACT_RESERVED_LO  = 3'd5;
   localparam logic [2:0] ACT_RESERVED_MID = 3'd6;
   localparam logic [2:0] ACT_RESERVED_HI  = 3'd7;

   typedef struct {
      logic [2:0]                       action;
      logic signed [dq_pkg::DATA_W-1:0] value;
      logic [POS_W-1:0]                 position;
      bit                               hold;
   } deque_req_type;

   typedef struct {
      dq_pkg::status_type               status;
      logic signed [dq_pkg::DATA_W-1:0] removed;
      logic [LEN_W-1:0]                 length;
   } deque_rsp_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [2:0]                       req_action = '0;
   logic signed [dq_pkg::DATA_W-1:0] req_value = '0;
   logic [POS_W-1:0]                 req_position = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [1:0]                       rsp_status;
   logic signed [dq_pkg::DATA_W-1:0] rsp_removed_value;
   logic [LEN_W-1:0]                 rsp_length;

   deque_req_type                    pending_reqs[$];
   deque_rsp_type                    expected_rsps[$];
   logic signed [dq_pkg::DATA_W-1:0] stored_cells[$];
   deque_req_type                    driven_req;
   int                               gen_len = 0;
   int                               accepted_reqs = 0;
   int                               fail_count = 0;
   int                               stall_cycles = 0;
   int                               send_idle_pct = 31;
   int                               recv_idle_pct = 71;

   bounded_deque_with_indexed_delete #(.DEPTH(DEPTH)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_length        (rsp_length)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // applies one request to the stored sequence and returns its response
   function automatic deque_rsp_type apply_deque_req(deque_req_type r);
      deque_rsp_type rsp;
      rsp.status  = dq_pkg::ST_DONE;
      rsp.removed = '0;
      case (r.action)
         dq_pkg::ACT_PUSH_FRONT: begin
            if (stored_cells.size() >= DEPTH) rsp.status = dq_pkg::ST_FULL;
            else stored_cells.push_front(r.value);
         end
         dq_pkg::ACT_PUSH_BACK: begin
            if (stored_cells.size() >= DEPTH) rsp.status = dq_pkg::ST_FULL;
            else stored_cells.push_back(r.value);
         end
         dq_pkg::ACT_POP_FRONT: begin
            if (stored_cells.size() == 0) rsp.status = dq_pkg::ST_NONE;
            else rsp.removed = stored_cells.pop_front();
         end
         dq_pkg::ACT_POP_BACK: begin
            if (stored_cells.size() == 0) rsp.status = dq_pkg::ST_NONE;
            else rsp.removed = stored_cells.pop_back();
         end
         dq_pkg::ACT_REMOVE: begin
            if (r.position >= stored_cells.size()) begin
               rsp.status = dq_pkg::ST_NONE;
            end else begin
               rsp.removed = stored_cells[r.position];
               stored_cells.delete(r.position);
            end
         end
         default: rsp.status = dq_pkg::ST_NONE;
      endcase
      rsp.length = LEN_W'(stored_cells.size());
      return rsp;
   endfunction

   // queues a request and keeps a rough length so removals can aim inside the sequence
   task automatic add_req(logic [2:0] act, logic signed [dq_pkg::DATA_W-1:0] val,
                          logic [POS_W-1:0] pos, bit hold);
      deque_req_type r;
      r.action   = act;
      r.value    = val;
      r.position = pos;
      r.hold     = hold;
      pending_reqs.push_back(r);
      case (act)
         dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: if (gen_len < DEPTH) gen_len++;
         dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK:   if (gen_len > 0) gen_len--;
         dq_pkg::ACT_REMOVE:                            if (pos < gen_len) gen_len--;
         default: ;
      endcase
   endtask

   function automatic logic signed [dq_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(19))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return -32'sd1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin : drive_reqs
      deque_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(apply_deque_req(driven_req));
            accepted_reqs++;
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                (!pending_reqs[0].hold || expected_rsps.size() == 0)) begin
               nxt = pending_reqs.pop_front();
               driven_req   = nxt;
               req_action   <= nxt.action;
               req_value    <= nxt.value;
               req_position <= nxt.position;
               req_valid    <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (accepted_reqs >= 2 * PHASE_LEN) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (accepted_reqs >= PHASE_LEN) begin
            send_idle_pct = 71;
            recv_idle_pct = 31;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : check_rsps
      deque_rsp_type exp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("unexpected response: status %0d removed %0d length %0d",
                           rsp_status, rsp_removed_value, rsp_length);
            end else begin
               exp = expected_rsps.pop_front();
               if (rsp_status !== exp.status || rsp_removed_value !== exp.removed ||
                   rsp_length !== exp.length) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                              exp.status, exp.removed, exp.length,
                              rsp_status, rsp_removed_value, rsp_length);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      int n;
      int run_len;
      int push_pct;
      int roll;
      logic [2:0] act;
      logic [POS_W-1:0] pos;

      // empty sequence: every removal and the reserved actions find nothing
      add_req(dq_pkg::ACT_POP_FRONT, '0, '0, 1'b0);
      add_req(dq_pkg::ACT_POP_BACK, -32'sd1, 4'hf, 1'b0);
      add_req(dq_pkg::ACT_REMOVE, '0, '0, 1'b0);
      add_req(ACT_RESERVED_LO, 32'sh7fffffff, '0, 1'b0);
      add_req(ACT_RESERVED_MID, '0, 4'h5, 1'b0);
      add_req(ACT_RESERVED_HI, 32'sh80000000, 4'hf, 1'b0);
      // fill from both ends, extremes first
      for (int i = 0; i < DEPTH; i++) begin
         case (i)
            0: add_req(dq_pkg::ACT_PUSH_FRONT, 32'sh7fffffff, '0, 1'b0);
            1: add_req(dq_pkg::ACT_PUSH_BACK, 32'sh80000000, '0, 1'b0);
            2: add_req(dq_pkg::ACT_PUSH_FRONT, -32'sd1, 4'hf, 1'b0);
            3: add_req(dq_pkg::ACT_PUSH_BACK, '0, 4'hf, 1'b0);
            default: add_req((i % 2) ? dq_pkg::ACT_PUSH_BACK : dq_pkg::ACT_PUSH_FRONT,
                             $urandom, POS_W'($urandom), 1'b0);
         endcase
      end
      add_req(dq_pkg::ACT_PUSH_FRONT, 32'sh12345678, '0, 1'b0);
      add_req(dq_pkg::ACT_PUSH_BACK, -32'sd2, '0, 1'b0);
      add_req(dq_pkg::ACT_REMOVE, '0, 4'hf, 1'b0);

      // runs that lean towards full, towards empty or neither
      n = 0;
      while (n < RANDOM_REQS) begin
         run_len = $urandom_range(40, 8);
         case ($urandom_range(2))
            0: push_pct = 85;
            1: push_pct = 15;
            default: push_pct = 50;
         endcase
         for (int k = 0; k < run_len && n < RANDOM_REQS; k++) begin
            roll = $urandom_range(99);
            pos  = POS_W'($urandom);
            if (roll < 2) begin
               act = 3'($urandom_range(ACT_RESERVED_HI, ACT_RESERVED_LO));
            end else if (roll < push_pct + 2) begin
               act = $urandom_range(1) ? dq_pkg::ACT_PUSH_BACK : dq_pkg::ACT_PUSH_FRONT;
            end else begin
               case ($urandom_range(2))
                  0: act = dq_pkg::ACT_POP_FRONT;
                  1: act = dq_pkg::ACT_POP_BACK;
                  default: begin
                     act = dq_pkg::ACT_REMOVE;
                     if (gen_len > 0 && $urandom_range(3) != 0)
                        pos = POS_W'($urandom_range(gen_len - 1));
                  end
               endcase
            end
            // sender waits for the block to drain now and then
            add_req(act, pick_value(), pos, (n % 150) == 149);
            n++;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
